// ----- src/sgmm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgmm_pkg: shared constants, types and helpers
// Sizes, opcodes and small arithmetic helpers for the half-pixel min/max block.
// ----------------------------------------------------------------------------
package sgmm_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int COL_W           = $clog2(MAX_WIDTH);
    localparam int PIX_W           = 8;
    localparam int CFG_W           = 11;
    localparam int ROW_WIDTH_RESET = 640;

    // op codes carried on the input tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // control carried with an item from the read stage to the result stage
    typedef struct packed {
        logic [COL_W-1:0] col;       // column of the reported pixel
        logic             first_col; // column 0: left neighbor is the pixel
        logic             last;      // last column: no right neighbor
        logic             above_ok;  // a row above the held row exists
        logic             flush;     // drain tick: below falls back to pixel
        logic             fwd;       // above entry is being written this edge
    } s1_ctrl_t;

    // saturated row width minus one, i.e. the index of the last column
    function automatic logic [COL_W-1:0] eff_last(input logic [CFG_W-1:0] rw);
        int w;
        w = int'(rw);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return COL_W'(w - 1);
    endfunction

    // truncated half-sum of two pixels
    function automatic logic [PIX_W-1:0] half_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

endpackage

// ----- src/subpixel_gray_minmax.sv -----
// ----------------------------------------------------------------------------
// subpixel_gray_minmax: half-pixel gray min/max over a raster stream
// Reports each pixel with the min and max of it and its neighbor half-sums.
// ----------------------------------------------------------------------------
// Usage: feed 8-bit gray pixels in raster order (tuser = 0), one image per
// frame, then send flush ticks (tuser = 1) to drain the last row, one result
// per tick; the drain ends the frame. Output lags input by one row: pixel
// (y,x) is reported when pixel (y+1,x) arrives, so the first row yields no
// results. Each result carries the pixel, the minimum and maximum over the
// pixel and the truncated half-sums (c+n)/2 with its left, above, below and
// right neighbors, and tlast on the last column. At column 0 the left
// neighbor, on the first row the above neighbor and on the last row the
// below neighbor fall back to the pixel itself; the right neighbor is left
// out on the last column. Rate: one transaction per clock, sustained while
// m_tready does not hold results back. A result's line-store reads are
// registered with its control at the accepting edge; min/max then goes into
// the output register once the output is free. Pixels sent during a drain,
// flushes mid-row and flushes with no row held are dropped with no result.
// row_width is to be written through the cfg channel only while the block
// is idle; the block itself does not enforce this. 0 reads as 1 and values
// above 1024 saturate to 1024. Line stores are not cleared after reset.
module subpixel_gray_minmax (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: row_width
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,     // [10:0] row_width
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] pixel
    input  logic        s_tuser,      // [0] op: 0 pixel, 1 flush
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [7:0] centre_value, [15:8] low_value,
                                      // [23:16] high_value
    output logic        m_tlast       // row_end
);

    localparam int CW = sgmm_pkg::COL_W;
    localparam int PW = sgmm_pkg::PIX_W;

    // line stores: held row and the row above it
    logic [PW-1:0] pend_mem  [sgmm_pkg::MAX_WIDTH];
    logic [PW-1:0] above_mem [sgmm_pkg::MAX_WIDTH];

    // control state
    logic [CW-1:0] width_last_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    rows_seen_reg, rows_seen_next;
    logic          flushing_reg, flushing_next;
    logic [PW-1:0] held_left_reg;

    // stage 1: memory read data plus item control
    logic                s1_valid_reg;
    sgmm_pkg::s1_ctrl_t  s1_reg, s1_next;
    logic [PW-1:0]       s1_px_reg;
    logic [PW-1:0]       pend_c_reg, pend_r_reg, above_rd_reg;
    logic [PW-1:0]       fwd_data_reg;

    // output register
    logic                m_tvalid_reg;
    logic [3*PW-1:0]     out_data_reg;
    logic                out_last_reg;

    logic          s_acc, out_free, s1_go;
    logic          op_flush, is_last, do_report, pend_we;
    logic [CW-1:0] col_inc;

    assign cfg_ready = 1'b1;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign op_flush = (s_tuser == sgmm_pkg::OP_FLUSH);
    assign is_last  = (col_reg >= width_last_reg);
    assign col_inc  = (col_reg == CW'(sgmm_pkg::MAX_WIDTH - 1)) ? '0 : col_reg + 1'b1;

    // ------------------------------------------------------------------
    // Stage 0: decide what the transaction does, advance position state
    // ------------------------------------------------------------------
    always_comb
    begin
        col_next       = col_reg;
        rows_seen_next = rows_seen_reg;
        flushing_next  = flushing_reg;
        do_report      = 1'b0;
        pend_we        = 1'b0;
        if (s_acc)
        begin
            if (!op_flush)
            begin
                // pixels during a drain are dropped
                if (!flushing_reg)
                begin
                    pend_we   = 1'b1;
                    do_report = (rows_seen_reg != 2'd0);
                    if (is_last)
                    begin
                        col_next = '0;
                        if (rows_seen_reg != 2'd2)
                            rows_seen_next = rows_seen_reg + 2'd1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
            else if (flushing_reg || (col_reg == '0 && rows_seen_reg != 2'd0))
            begin
                do_report = 1'b1;
                if (is_last)
                begin
                    col_next       = '0;
                    rows_seen_next = 2'd0;
                    flushing_next  = 1'b0;
                end
                else
                begin
                    col_next      = col_inc;
                    flushing_next = 1'b1;
                end
            end
        end
    end

    // stage-1 control for the item entering now
    always_comb
    begin
        s1_next.col       = col_reg;
        s1_next.first_col = (col_reg == '0);
        s1_next.last      = is_last;
        s1_next.above_ok  = (rows_seen_reg == 2'd2);
        s1_next.flush     = op_flush;
        // the item leaving stage 1 at this edge writes above[col]; the
        // read below returns the old entry, so carry the new one along
        s1_next.fwd       = s1_valid_reg && !s1_reg.flush && (s1_reg.col == col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg <= sgmm_pkg::eff_last(sgmm_pkg::CFG_W'(sgmm_pkg::ROW_WIDTH_RESET));
            col_reg        <= '0;
            rows_seen_reg  <= 2'd0;
            flushing_reg   <= 1'b0;
            held_left_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_last_reg <= sgmm_pkg::eff_last(cfg_data);
            col_reg       <= col_next;
            rows_seen_reg <= rows_seen_next;
            flushing_reg  <= flushing_next;
            if (s_acc)
                s1_valid_reg <= do_report;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
            begin
                held_left_reg <= pend_c_reg;
                m_tvalid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // stage-1 payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_reg       <= s1_next;
            s1_px_reg    <= s_tdata;
            fwd_data_reg <= pend_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read-first, read data registered, no combinational read latency
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[col_reg] <= s_tdata;
        if (s_acc)
        begin
            pend_c_reg <= pend_mem[col_reg];
            pend_r_reg <= pend_mem[col_inc];
        end
    end

    always_ff @(posedge clk)
    begin
        // held pixel moves up once it has been reported against a new row
        if (s1_go && !s1_reg.flush)
            above_mem[s1_reg.col] <= pend_c_reg;
        if (s_acc)
            above_rd_reg <= above_mem[col_reg];
    end

    // ------------------------------------------------------------------
    // Stage 1: half-sums and min/max
    // ------------------------------------------------------------------
    logic [PW-1:0] c_px, left_px, up_px, down_px;
    logic [PW-1:0] h_left, h_up, h_down, h_right;
    logic [PW-1:0] lo, hi;

    always_comb
    begin
        c_px    = pend_c_reg;
        left_px = s1_reg.first_col ? c_px : held_left_reg;
        if (s1_reg.above_ok)
            up_px = s1_reg.fwd ? fwd_data_reg : above_rd_reg;
        else
            up_px = c_px;
        down_px = s1_reg.flush ? c_px : s1_px_reg;

        h_left  = sgmm_pkg::half_sum(c_px, left_px);
        h_up    = sgmm_pkg::half_sum(c_px, up_px);
        h_down  = sgmm_pkg::half_sum(c_px, down_px);
        h_right = sgmm_pkg::half_sum(c_px, pend_r_reg);

        lo = c_px;
        hi = c_px;
        if (h_left < lo) lo = h_left;
        if (h_left > hi) hi = h_left;
        if (h_up < lo)   lo = h_up;
        if (h_up > hi)   hi = h_up;
        if (h_down < lo) lo = h_down;
        if (h_down > hi) hi = h_down;
        if (!s1_reg.last)
        begin
            if (h_right < lo) lo = h_right;
            if (h_right > hi) hi = h_right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_data_reg <= {hi, lo, c_px};
            out_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a result always brackets its own pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:8] <= m_tdata[7:0]) && (m_tdata[7:0] <= m_tdata[23:16]))
        else $error("low/centre/high out of order");

    // a stalled stage 1 must hold off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !s_tready)
        else $error("input accepted over a stalled stage 1");

    // a drain only runs while a row is held
    assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> (rows_seen_reg != 2'd0))
        else $error("drain running with no row held");

    // row count saturates at two
    assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg != 2'd3)
        else $error("row count overflow");

endmodule
